// ===== rtl/core/irxb_pkg.sv =====
// irxb_pkg: shared widths, codes and default sizes of the x2 resampler
// no dependencies; used by the interfaces, the top level, the checker and the testbench
package irxb_pkg;

    localparam int MAX_WIDTH_DEF    = 64;
    localparam int MAX_HEIGHT_DEF   = 64;
    localparam int CHANNEL_BITS_DEF = 16;

    localparam int POS_W   = 8;
    localparam int CH_W    = 16;
    localparam int SIZE_W  = 7;
    localparam int SCALE_W = 20;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = POS_W + SCALE_W;
    localparam int IP_W    = PROD_W - FRAC_W;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = SCALE_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic MODE_DOUBLE = 1'b0;
    localparam logic MODE_HALVE  = 1'b1;

    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_W   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SRC_H   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE_Y = 3'd4;

    localparam logic [SIZE_W-1:0]  RST_SIZE  = 7'd64;
    localparam logic [SCALE_W-1:0] RST_SCALE = 20'd32768;

endpackage

// ===== rtl/core/irxb_if.sv =====
// irxb_in_if, irxb_out_if, irxb_cfg_if: valid/ready channels of the resampler
// depends on irxb_pkg
interface irxb_in_if;
    import irxb_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    modport source (output valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface irxb_out_if;
    import irxb_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface irxb_cfg_if;
    import irxb_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/irxb_ram.sv =====
// irxb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module irxb_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/image_resample_x2_bilinear_box_top.sv =====
// image_resample_x2_bilinear_box_top: source pixel store and x2 bilinear / box resampler
// depends on irxb_pkg, irxb_if, irxb_ram
module image_resample_x2_bilinear_box_top #(
    parameter int MAX_WIDTH    = irxb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = irxb_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = irxb_pkg::CHANNEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irxb_in_if.sink     i_in,
    irxb_out_if.source  o_out,
    irxb_cfg_if.sink    i_cfg
);
    // One word is taken per clock while input ready is high, writes and samples
    // alike, and each sample passes stages a to e. The store is split into four
    // banks by column and row parity, so the four neighbours of a sample are
    // read together, one per bank. A result that is not taken is held in
    // the output register and one skid register; input ready drops only when
    // both are full. The store has no clearing pass and is usable right after
    // reset; a sample must only touch pixels that were written. Configuration
    // is taken every cycle and must only change while no word is in flight.
    import irxb_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CB  = CHANNEL_BITS;
    localparam int PW  = 3 * CB;
    localparam int HW  = (MAX_WIDTH + 1) / 2;
    localparam int HH  = (MAX_HEIGHT + 1) / 2;
    localparam int BD  = HW * HH;
    localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int WW  = FRAC_W + 1;
    localparam int LW  = CB + WW;
    localparam int EW  = LW + WW + 1;
    localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_W;

    // configuration
    logic                r_mode;
    logic [SIZE_W-1:0]   r_src_w, r_src_h;
    logic [SCALE_W-1:0]  r_scale_x, r_scale_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DOUBLE;
            r_src_w   <= RST_SIZE;
            r_src_h   <= RST_SIZE;
            r_scale_x <= RST_SCALE;
            r_scale_y <= RST_SCALE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:    r_mode    <= i_cfg.data[0];
                REG_SRC_W:   r_src_w   <= i_cfg.data[SIZE_W-1:0];
                REG_SRC_H:   r_src_h   <= i_cfg.data[SIZE_W-1:0];
                REG_SCALE_X: r_scale_x <= i_cfg.data[SCALE_W-1:0];
                REG_SCALE_Y: r_scale_y <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [IP_W-1:0] last_idx(input logic [SIZE_W-1:0] s, input int m);
        logic [IP_W-1:0] v;
        v = IP_W'(s);
        if (v == '0) begin
            return '0;
        end else if (v > IP_W'(m)) begin
            return IP_W'(m - 1);
        end
        return v - IP_W'(1);
    endfunction

    logic [IP_W-1:0] w_wm1, w_hm1;
    assign w_wm1 = last_idx(r_src_w, MAX_WIDTH);
    assign w_hm1 = last_idx(r_src_h, MAX_HEIGHT);

    // pipeline control and output skid
    logic            w_adv;
    logic            r_out_vld, r_skid_vld;
    logic [3*CH_W-1:0] r_out_pix, r_skid_pix;
    logic            r_e_vld;
    logic [PW-1:0]   r_e_res;
    logic [3*CH_W-1:0] w_e_out;

    assign w_adv      = !r_skid_vld;
    assign i_in.ready = w_adv;

    // stage a: coordinate products
    logic              r_a_vld, r_a_op;
    logic [POS_W-1:0]  r_a_px, r_a_py;
    logic [PW-1:0]     r_a_pix;
    logic [PROD_W-1:0] r_a_fx, r_a_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in.valid;
        end
        if (w_adv) begin
            r_a_op  <= i_in.opcode;
            r_a_px  <= i_in.pos_x;
            r_a_py  <= i_in.pos_y;
            r_a_pix <= {CB'(i_in.red_in), CB'(i_in.green_in), CB'(i_in.blue_in)};
            r_a_fx  <= PROD_W'(i_in.pos_x) * PROD_W'(r_scale_x);
            r_a_fy  <= PROD_W'(i_in.pos_y) * PROD_W'(r_scale_y);
        end
    end

    // stage b: clamp to source, select neighbours
    logic              r_b_vld, r_b_op, r_b_we;
    logic [XW-1:0]     r_b_x0, r_b_x1;
    logic [YW-1:0]     r_b_y0, r_b_y1;
    logic [FRAC_W-1:0] r_b_fx, r_b_fy;
    logic [PW-1:0]     r_b_pix;
    logic [IP_W-1:0]   w_ix0, w_ix1, w_iy0, w_iy1, w_ipx, w_ipy;
    logic [XW-1:0]     n_b_x0, n_b_x1;
    logic [YW-1:0]     n_b_y0, n_b_y1;
    logic              n_b_we;

    assign w_ipx = r_a_fx[PROD_W-1:FRAC_W];
    assign w_ipy = r_a_fy[PROD_W-1:FRAC_W];
    assign w_ix0 = (w_ipx > w_wm1) ? w_wm1 : w_ipx;
    assign w_ix1 = (w_ix0 == w_wm1) ? w_wm1 : w_ix0 + IP_W'(1);
    assign w_iy0 = (w_ipy > w_hm1) ? w_hm1 : w_ipy;
    assign w_iy1 = (w_iy0 == w_hm1) ? w_hm1 : w_iy0 + IP_W'(1);

    always_comb begin
        n_b_we = 1'b0;
        if (r_a_op == OP_WRITE) begin
            n_b_x0 = XW'(r_a_px);
            n_b_x1 = XW'(r_a_px);
            n_b_y0 = YW'(r_a_py);
            n_b_y1 = YW'(r_a_py);
            n_b_we = r_a_vld && (IP_W'(r_a_px) < IP_W'(MAX_WIDTH))
                             && (IP_W'(r_a_py) < IP_W'(MAX_HEIGHT));
        end else begin
            n_b_x0 = XW'(w_ix0);
            n_b_x1 = XW'(w_ix1);
            n_b_y0 = YW'(w_iy0);
            n_b_y1 = YW'(w_iy1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_b_we  <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
            r_b_we  <= n_b_we;
        end
        if (w_adv) begin
            r_b_op  <= r_a_op;
            r_b_x0  <= n_b_x0;
            r_b_x1  <= n_b_x1;
            r_b_y0  <= n_b_y0;
            r_b_y1  <= n_b_y1;
            r_b_fx  <= r_a_fx[FRAC_W-1:0];
            r_b_fy  <= r_a_fy[FRAC_W-1:0];
            r_b_pix <= r_a_pix;
        end
    end

    // parity banks, bank index is {row parity, column parity}
    logic [PW-1:0] w_bank [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [XW-1:0] w_xs;
        logic [YW-1:0] w_ys;
        logic [AW-1:0] w_addr;
        logic          w_we;

        assign w_xs   = (r_b_x0[0] == 1'(b % 2)) ? r_b_x0 : r_b_x1;
        assign w_ys   = (r_b_y0[0] == 1'(b / 2)) ? r_b_y0 : r_b_y1;
        assign w_addr = AW'((w_ys >> 1) * HW + (w_xs >> 1));
        assign w_we   = w_adv && r_b_we && ({r_b_y0[0], r_b_x0[0]} == 2'(b));

        irxb_ram #(.WIDTH(PW), .DEPTH(BD), .ADDR_W(AW)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_addr),
            .i_wdata (r_b_pix),
            .i_re    (w_adv),
            .i_raddr (w_addr),
            .o_rdata (w_bank[b])
        );
    end

    // stage c: bank read data
    logic              r_c_vld, r_c_x0p, r_c_x1p, r_c_y0p, r_c_y1p;
    logic [FRAC_W-1:0] r_c_fx, r_c_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_b_vld && (r_b_op == OP_SAMPLE);
        end
        if (w_adv) begin
            r_c_x0p <= r_b_x0[0];
            r_c_x1p <= r_b_x1[0];
            r_c_y0p <= r_b_y0[0];
            r_c_y1p <= r_b_y1[0];
            r_c_fx  <= r_b_fx;
            r_c_fy  <= r_b_fy;
        end
    end

    // stage d: horizontal blend and box average
    logic [PW-1:0] w_p00, w_p10, w_p01, w_p11;
    logic [WW-1:0] w_wx0, w_wx1;
    logic          r_d_vld;
    logic [LW-1:0] r_d_top [3];
    logic [LW-1:0] r_d_bot [3];
    logic [CB-1:0] r_d_box [3];
    logic [WW-1:0] r_d_wy0, r_d_wy1;
    logic [LW-1:0] n_d_top [3];
    logic [LW-1:0] n_d_bot [3];
    logic [CB-1:0] n_d_box [3];

    assign w_p00 = w_bank[{r_c_y0p, r_c_x0p}];
    assign w_p10 = w_bank[{r_c_y0p, r_c_x1p}];
    assign w_p01 = w_bank[{r_c_y1p, r_c_x0p}];
    assign w_p11 = w_bank[{r_c_y1p, r_c_x1p}];
    assign w_wx1 = WW'(r_c_fx);
    assign w_wx0 = ONE_W - w_wx1;

    for (genvar c = 0; c < 3; c++) begin : g_hblend
        logic [CB+1:0] w_sum;
        assign n_d_top[c] = LW'(w_p00[c*CB +: CB]) * LW'(w_wx0)
                          + LW'(w_p10[c*CB +: CB]) * LW'(w_wx1);
        assign n_d_bot[c] = LW'(w_p01[c*CB +: CB]) * LW'(w_wx0)
                          + LW'(w_p11[c*CB +: CB]) * LW'(w_wx1);
        assign w_sum = (CB+2)'(w_p00[c*CB +: CB]) + (CB+2)'(w_p10[c*CB +: CB])
                     + (CB+2)'(w_p01[c*CB +: CB]) + (CB+2)'(w_p11[c*CB +: CB])
                     + (CB+2)'(2);
        assign n_d_box[c] = w_sum[CB+1:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
        end
        if (w_adv) begin
            r_d_top <= n_d_top;
            r_d_bot <= n_d_bot;
            r_d_box <= n_d_box;
            r_d_wy1 <= WW'(r_c_fy);
            r_d_wy0 <= ONE_W - WW'(r_c_fy);
        end
    end

    // stage e: vertical blend with rounding, mode select
    logic [PW-1:0] n_e_res;

    for (genvar c = 0; c < 3; c++) begin : g_vblend
        logic [EW-1:0] w_acc;
        assign w_acc = EW'(r_d_top[c]) * EW'(r_d_wy0) + EW'(r_d_bot[c]) * EW'(r_d_wy1)
                     + (EW'(1) << (2 * FRAC_W - 1));
        assign n_e_res[c*CB +: CB] = (r_mode == MODE_HALVE)
                                   ? r_d_box[c] : w_acc[CB+2*FRAC_W-1:2*FRAC_W];
        assign w_e_out[(2-c)*CH_W +: CH_W] = CH_W'(r_e_res[(2-c)*CB +: CB]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld;
        end
        if (w_adv) begin
            r_e_res <= n_e_res;
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_e_vld;
            end
        end else if (r_e_vld && w_adv) begin
            r_skid_vld <= 1'b1;
        end
        if (!r_out_vld || o_out.ready) begin
            r_out_pix <= r_skid_vld ? r_skid_pix : w_e_out;
        end else if (w_adv) begin
            r_skid_pix <= w_e_out;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.red_out   = r_out_pix[2*CH_W +: CH_W];
    assign o_out.green_out = r_out_pix[CH_W +: CH_W];
    assign o_out.blue_out  = r_out_pix[0 +: CH_W];
endmodule

// ===== rtl/core/irxb_checker.sv =====
// irxb_checker: port-level assertions of the resampler, bound to the top level
// depends on irxb_pkg and image_resample_x2_bilinear_box_top
module irxb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_cfg_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [3*irxb_pkg::CH_W-1:0] i_out_word
);
    import irxb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_word))
        else $error("output word changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> i_in_ready)
        else $error("input stalled after output word taken");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");
endmodule

bind image_resample_x2_bilinear_box_top irxb_checker u_irxb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  ({o_out.red_out, o_out.green_out, o_out.blue_out})
);

// ===== sim/image_resample_x2_bilinear_box_top_tb.sv =====
// image_resample_x2_bilinear_box_top_tb: write/sample stimulus with a pixel-store predictor
// depends on irxb_pkg, irxb_if and the image_resample_x2_bilinear_box_top rtl
module image_resample_x2_bilinear_box_top_tb;
    import irxb_pkg::*;

    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    class pixel_scoreboard;
        t_rgb            store [0:4095];
        bit              written [0:4095];
        logic            mode_q;
        int unsigned     width_q;
        int unsigned     height_q;
        int unsigned     step_x;
        int unsigned     step_y;
        t_rgb            pending [$];
        int              errors;
        int              samples;
        int              writes;

        function new();
            mode_q = MODE_DOUBLE;
            width_q = RST_SIZE;
            height_q = RST_SIZE;
            step_x = RST_SCALE;
            step_y = RST_SCALE;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
            case (idx)
                REG_MODE:    mode_q = d[0];
                REG_SRC_W:   width_q = d[6:0];
                REG_SRC_H:   height_q = d[6:0];
                REG_SCALE_X: step_x = d;
                REG_SCALE_Y: step_y = d;
                default: ;
            endcase
        endfunction

        function int unsigned eff_size(int unsigned v);
            if (v == 0) return 1;
            return v > 64 ? 64 : v;
        endfunction

        function void map_axis(int unsigned pos, int unsigned stp, int unsigned sz,
                               output int unsigned i0, output int unsigned i1,
                               output longint unsigned fr);
            longint unsigned f;
            f = longint'(pos) * stp;
            i0 = (f >> 16) > sz - 1 ? sz - 1 : int'(f >> 16);
            i1 = i0 + 1 > sz - 1 ? sz - 1 : i0 + 1;
            fr = f & 16'hFFFF;
        endfunction

        function bit covered(int unsigned px, int unsigned py);
            int unsigned x0, x1, y0, y1;
            longint unsigned fx, fy;
            map_axis(px, step_x, eff_size(width_q), x0, x1, fx);
            map_axis(py, step_y, eff_size(height_q), y0, y1, fy);
            return written[y0*64+x0] && written[y0*64+x1] &&
                   written[y1*64+x0] && written[y1*64+x1];
        endfunction

        function void note_input(logic op, logic [7:0] px, logic [7:0] py, t_rgb pix);
            int unsigned x0, x1, y0, y1;
            longint unsigned fx, fy, s, wx0, wy0;
            t_rgb n [4];
            t_rgb r;
            logic [CH_W-1:0] c [4][3];
            logic [CH_W-1:0] o [3];
            if (op == OP_WRITE) begin
                if (px < 64 && py < 64) begin
                    store[py*64+px] = pix;
                    written[py*64+px] = 1;
                end
                writes++;
                return;
            end
            map_axis(px, step_x, eff_size(width_q), x0, x1, fx);
            map_axis(py, step_y, eff_size(height_q), y0, y1, fy);
            n[0] = store[y0*64+x0];
            n[1] = store[y0*64+x1];
            n[2] = store[y1*64+x0];
            n[3] = store[y1*64+x1];
            for (int k = 0; k < 4; k++) begin
                c[k][0] = n[k].red;
                c[k][1] = n[k].green;
                c[k][2] = n[k].blue;
            end
            wx0 = 65536 - fx;
            wy0 = 65536 - fy;
            for (int ch = 0; ch < 3; ch++) begin
                if (mode_q == MODE_DOUBLE) begin
                    s = c[0][ch]*(wx0*wy0) + c[1][ch]*(fx*wy0)
                      + c[2][ch]*(wx0*fy) + c[3][ch]*(fx*fy);
                    s = (s + 64'h8000_0000) >> 32;
                end else begin
                    s = (longint'(c[0][ch]) + c[1][ch] + c[2][ch] + c[3][ch] + 2) >> 2;
                end
                o[ch] = s[15:0];
            end
            r.red = o[0];
            r.green = o[1];
            r.blue = o[2];
            pending.push_back(r);
            samples++;
        endfunction

        function void check_result(t_rgb got);
            t_rgb exp_pix;
            if (pending.size() == 0) begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp_pix = pending.pop_front();
            if (got.red !== exp_pix.red) begin
                $error("red_out expected %h actual %h", exp_pix.red, got.red);
                errors++;
            end
            if (got.green !== exp_pix.green) begin
                $error("green_out expected %h actual %h", exp_pix.green, got.green);
                errors++;
            end
            if (got.blue !== exp_pix.blue) begin
                $error("blue_out expected %h actual %h", exp_pix.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    irxb_in_if  in_ch ();
    irxb_out_if out_ch ();
    irxb_cfg_if cfg_ch ();

    image_resample_x2_bilinear_box_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    pixel_scoreboard sb;
    int send_idle;
    int recv_idle;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("image_resample_x2_bilinear_box_top: mismatch");
        $finish;
    end

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.red_out, out_ch.green_out, out_ch.blue_out});
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    // valid stays up after a take until the next word or an idle cycle
    task automatic send_word(logic op, logic [7:0] px, logic [7:0] py, t_rgb pix);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.opcode <= op;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        in_ch.red_in <= pix.red;
        in_ch.green_in <= pix.green;
        in_ch.blue_in <= pix.blue;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, px, py, pix);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_rgb rand_pix();
        t_rgb p;
        p = 48'({$urandom, $urandom});
        return p;
    endfunction

    task automatic sample_rand();
        logic [7:0] px, py;
        int tries;
        tries = 0;
        do begin
            px = ($urandom_range(3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(130));
            py = ($urandom_range(3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(130));
            tries++;
        end while (!sb.covered(px, py) && tries < 50);
        if (sb.covered(px, py))
            send_word(OP_SAMPLE, px, py, rand_pix());
    endtask

    // sizes, scales and mode for one phase
    task automatic configure(int unsigned w, int unsigned h, logic m);
        int unsigned ew, eh;
        ew = w == 0 ? 1 : (w > 64 ? 64 : w);
        eh = h == 0 ? 1 : (h > 64 ? 64 : h);
        drain();
        write_reg(REG_MODE, DATA_W'(m));
        write_reg(REG_SRC_W, DATA_W'(w));
        write_reg(REG_SRC_H, DATA_W'(h));
        write_reg(REG_SCALE_X, DATA_W'(ew > 1 ? ((ew - 1) * 65536) / (2 * ew - 1) : 0));
        write_reg(REG_SCALE_Y, DATA_W'(eh > 1 ? ((eh - 1) * 65536) / (2 * eh - 1) : 0));
        write_reg(REG_NONE, DATA_W'($urandom));
    endtask

    initial begin
        t_rgb ones;
        sb = new();
        send_idle = 0;
        recv_idle = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.opcode = OP_WRITE;
        in_ch.pos_x = 0;
        in_ch.pos_y = 0;
        in_ch.red_in = 0;
        in_ch.green_in = 0;
        in_ch.blue_in = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_MODE;
        cfg_ch.data = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: corners, extremes, out of store writes
        ones = '1;
        send_word(OP_WRITE, 8'd0, 8'd0, ones);
        send_word(OP_WRITE, 8'd1, 8'd0, '0);
        send_word(OP_WRITE, 8'd0, 8'd1, '0);
        send_word(OP_WRITE, 8'd1, 8'd1, ones);
        send_word(OP_WRITE, 8'd255, 8'd255, ones);
        send_word(OP_WRITE, 8'd64, 8'd3, '0);
        send_word(OP_WRITE, 8'd3, 8'd64, '0);
        configure(2, 2, MODE_DOUBLE);
        write_reg(REG_SCALE_X, 20'hFFFFF);
        send_word(OP_SAMPLE, 8'd0, 8'd0, '0);
        send_word(OP_SAMPLE, 8'd1, 8'd1, '0);
        send_word(OP_SAMPLE, 8'd255, 8'd255, ones);
        drain();
        write_reg(REG_SCALE_X, 20'h08000);
        write_reg(REG_SCALE_Y, 20'h0C000);
        send_word(OP_SAMPLE, 8'd1, 8'd1, '0);
        drain();
        write_reg(REG_MODE, DATA_W'(MODE_HALVE));
        send_word(OP_SAMPLE, 8'd0, 8'd0, '0);
        send_word(OP_SAMPLE, 8'd2, 8'd2, '0);
        configure(0, 127, MODE_HALVE);
        send_word(OP_SAMPLE, 8'd0, 8'd0, '0);
        configure(1, 1, MODE_DOUBLE);
        send_word(OP_SAMPLE, 8'd9, 8'd200, '0);

        for (int ph = 0; ph < 6; ph++) begin
            int unsigned w, h;
            send_idle = ph < 2 ? 19 : (ph < 4 ? 85 : 0);
            recv_idle = ph < 2 ? 85 : (ph < 4 ? 19 : 0);
            w = (ph == 5) ? 64 : $urandom_range(1, 12);
            h = (ph == 4) ? 64 : $urandom_range(1, 12);
            configure(w, h, ph[0]);
            for (int y = 0; y < (h > 64 ? 64 : h); y++)
                for (int x = 0; x < (w > 64 ? 64 : w); x++)
                    if (w * h <= 150 || $urandom_range(3) == 0)
                        send_word(OP_WRITE, POS_W'(x), POS_W'(y), rand_pix());
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(4) == 0)
                    send_word(OP_WRITE, POS_W'($urandom),
                              ($urandom_range(3) != 0) ? POS_W'($urandom_range(63))
                                                       : POS_W'($urandom),
                              rand_pix());
                else
                    sample_rand();
            end
        end

        drain();
        $display("covered %0d pixel writes and %0d samples in both modes over several sizes",
                 sb.writes, sb.samples);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("image_resample_x2_bilinear_box_top: match");
        else
            $display("image_resample_x2_bilinear_box_top: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/irxb_pkg.sv
rtl/core/irxb_if.sv
rtl/core/irxb_ram.sv
rtl/core/image_resample_x2_bilinear_box_top.sv
rtl/core/irxb_checker.sv
sim/image_resample_x2_bilinear_box_top_tb.sv
